// ===== rtl/core/lcc_pkg.sv =====
package lcc_pkg;

  localparam int DIGIT_W       = 4;
  localparam int DIGIT_TOTAL_W = 5;
  localparam int BRAND_W       = 2;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [BRAND_W-1:0] brand_t;

  localparam brand_t BRAND_NONE  = 2'd0;
  localparam brand_t BRAND_LEAD4 = 2'd1;
  localparam brand_t BRAND_P34_37 = 2'd2;
  localparam brand_t BRAND_P51_55 = 2'd3;

  // card lengths and prefix digits used by the brand decode, and the constants of the luhn sum
  localparam int LEN_SHORT = 13;
  localparam int LEN_MID   = 15;
  localparam int LEN_LONG  = 16;

  localparam digit_t DIG_ONE   = 4'd1;
  localparam digit_t DIG_THREE = 4'd3;
  localparam digit_t DIG_FOUR  = 4'd4;
  localparam digit_t DIG_FIVE  = 4'd5;
  localparam digit_t DIG_SEVEN = 4'd7;
  localparam digit_t DIG_NINE  = 4'd9;
  localparam digit_t DIG_TEN   = 4'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_DRAIN,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic clear;
    logic conv;
    logic drain;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/lcc_in_if.sv =====
interface lcc_in_if #(
  parameter int INPUT_BITS = 63
);
  logic                  valid;
  logic                  ready;
  logic [INPUT_BITS-1:0] card_number;

  modport source (output valid, output card_number, input ready);
  modport sink (input valid, input card_number, output ready);
endinterface

// ===== rtl/core/lcc_out_if.sv =====
interface lcc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] brand;
  logic [4:0] digit_total;
  logic       checksum_ok;

  modport source (output valid, output brand, output digit_total, output checksum_ok,
                  input ready);
  modport sink (input valid, input brand, input digit_total, input checksum_ok,
                output ready);
endinterface

// ===== rtl/core/lcc_cell.sv =====
module lcc_cell
  import lcc_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       carry_in,
  input  digit_t     upper_digit,
  output logic       carry_out,
  output digit_t     digit
);

  digit_t digit_r;
  digit_t digit_nxt;
  digit_t adj;

  // add-3 correction before the shift keeps the digit in bcd range
  assign adj       = (digit_r >= DIG_FIVE) ? digit_r + DIG_THREE : digit_r;
  assign carry_out = adj[DIGIT_W-1];
  assign digit     = digit_r;

  always_comb begin
    digit_nxt = digit_r;
    if (ctrl.clear) begin
      digit_nxt = '0;
    end else if (ctrl.conv) begin
      digit_nxt = {adj[DIGIT_W-2:0], carry_in};
    end else if (ctrl.drain) begin
      digit_nxt = upper_digit;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

// ===== rtl/core/lcc_luhn_acc.sv =====
module lcc_luhn_acc
  import lcc_pkg::*;
#(
  parameter int CW = 5
)
(
  input  logic          clk,
  input  logic          clear,
  input  logic          step,
  input  digit_t        digit,
  output brand_t        brand,
  output logic [CW-1:0] count,
  output logic          checksum_ok
);

  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] count_r, count_nxt;
  digit_t        sum_r, sum_nxt;
  digit_t        lead_r, lead_nxt;
  digit_t        next_r, next_nxt;
  digit_t        prev_r, prev_nxt;
  digit_t        dbl;
  digit_t        term;
  logic [DIGIT_W:0] raw_sum;

  // doubled digit folded to its digit sum: 2d - 9 when 2d > 9
  always_comb begin
    dbl = {digit[DIGIT_W-2:0], 1'b0};
    if (digit > 4'd4) begin
      dbl = {digit[DIGIT_W-2:0], 1'b0} - DIG_NINE;
    end
    term    = idx_r[0] ? dbl : digit;
    raw_sum = {1'b0, sum_r} + {1'b0, term};
  end

  always_comb begin
    idx_nxt   = idx_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    lead_nxt  = lead_r;
    next_nxt  = next_r;
    prev_nxt  = prev_r;
    if (clear) begin
      idx_nxt   = '0;
      count_nxt = '0;
      sum_nxt   = '0;
      lead_nxt  = '0;
      next_nxt  = '0;
      prev_nxt  = '0;
    end else if (step) begin
      idx_nxt  = idx_r + 1'b1;
      prev_nxt = digit;
      // running sum kept mod 10
      if (raw_sum >= {1'b0, DIG_TEN}) begin
        sum_nxt = DIGIT_W'(raw_sum - {1'b0, DIG_TEN});
      end else begin
        sum_nxt = raw_sum[DIGIT_W-1:0];
      end
      if (digit != '0) begin
        count_nxt = idx_r + 1'b1;
        lead_nxt  = digit;
        next_nxt  = prev_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    count_r <= count_nxt;
    sum_r   <= sum_nxt;
    lead_r  <= lead_nxt;
    next_r  <= next_nxt;
    prev_r  <= prev_nxt;
  end

  always_comb begin
    checksum_ok = (sum_r == '0);
    count       = count_r;
    brand       = BRAND_NONE;
    if (checksum_ok) begin
      if ((count_r == CW'(LEN_SHORT) || count_r == CW'(LEN_LONG)) && lead_r == DIG_FOUR) begin
        brand = BRAND_LEAD4;
      end else if (count_r == CW'(LEN_MID) && lead_r == DIG_THREE &&
                   (next_r == DIG_FOUR || next_r == DIG_SEVEN)) begin
        brand = BRAND_P34_37;
      end else if (count_r == CW'(LEN_LONG) && lead_r == DIG_FIVE &&
                   next_r >= DIG_ONE && next_r <= DIG_FIVE) begin
        brand = BRAND_P51_55;
      end
    end
  end

endmodule

// ===== rtl/core/luhn_card_number_classifier.sv =====
// channel | dir | signals                                        | transfer
// in_ch   | in  | valid, ready, card_number[INPUT_BITS-1:0]      | valid && ready
// out_ch  | out | valid, ready, brand[1:0], digit_total[4:0],    | valid && ready
//         |     | checksum_ok                                    |
//
// one card number at a time: an accept, a shift-add of every input bit through the
// row of bcd cells, a drain of the NDIG digits into the luhn accumulator, and a load;
// a new card is taken only once the load of the last one is done.
// rst_n is synchronous, active low, and clears the sequencer and the output valid.
// the output register lets the next item be taken while a result waits; a stalled
// result holds the block in the load cycle until it is taken.
module luhn_card_number_classifier
  import lcc_pkg::*;
#(
  parameter int INPUT_BITS = 63
)
(
  input  logic      clk,
  input  logic      rst_n,
  lcc_in_if.sink    in_ch,
  lcc_out_if.source out_ch
);

  localparam int NDIG = (INPUT_BITS * 30103) / 100000 + 1;
  localparam int CW   = $clog2(NDIG + 1);
  localparam int TW   = $clog2(INPUT_BITS);

  state_t state_r, state_nxt;
  logic [TW-1:0]         cnt_r, cnt_nxt;
  logic [INPUT_BITS-1:0] shift_r, shift_nxt;
  logic                  out_valid_r, out_valid_nxt;
  brand_t                brand_r;
  logic [DIGIT_TOTAL_W-1:0] total_r;
  logic                  ok_r;

  logic       accept;
  logic       load_out;
  cell_ctrl_t ctrl;
  logic [NDIG:0] carry;
  digit_t        digits [NDIG+1];
  brand_t        acc_brand;
  logic [CW-1:0] acc_count;
  logic          acc_ok;

  assign accept = in_ch.valid && in_ch.ready;

  // bcd cell row, least significant digit in cell 0
  assign carry[0]     = shift_r[INPUT_BITS-1];
  assign digits[NDIG] = '0;

  for (genvar k = 0; k < NDIG; k++) begin : g_cell
    lcc_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .carry_in    (carry[k]),
      .upper_digit (digits[k+1]),
      .carry_out   (carry[k+1]),
      .digit       (digits[k])
    );
  end

  lcc_luhn_acc #(
    .CW (CW)
  ) u_acc (
    .clk         (clk),
    .clear       (accept),
    .step        (ctrl.drain),
    .digit       (digits[0]),
    .brand       (acc_brand),
    .count       (acc_count),
    .checksum_ok (acc_ok)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (cnt_r == TW'(INPUT_BITS - 1)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (cnt_r == TW'(NDIG - 1)) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready = 1'b0;
    ctrl        = '0;
    load_out    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        ctrl.clear  = in_ch.valid;
      end
      ST_CONV:  ctrl.conv  = 1'b1;
      ST_DRAIN: ctrl.drain = 1'b1;
      ST_LOAD:  load_out   = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (state_r != state_nxt) begin
      cnt_nxt = '0;
    end else if (ctrl.conv || ctrl.drain) begin
      cnt_nxt = cnt_r + 1'b1;
    end

    shift_nxt = shift_r;
    if (accept) begin
      shift_nxt = in_ch.card_number;
    end else if (ctrl.conv) begin
      shift_nxt = {shift_r[INPUT_BITS-2:0], 1'b0};
    end

    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    if (load_out) begin
      brand_r <= acc_brand;
      total_r <= DIGIT_TOTAL_W'(acc_count);
      ok_r    <= acc_ok;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.brand       = brand_r;
  assign out_ch.digit_total = total_r;
  assign out_ch.checksum_ok = ok_r;

endmodule

// ===== bench/card_check_monitor.sv =====
`timescale 1ns / 1ps

module card_check_monitor
  import lcc_pkg::*;
#(
  parameter int INPUT_BITS = 63
)
(
  input  logic clk,
  input  logic rst_n,
  lcc_in_if    in_ch,
  lcc_out_if   out_ch,
  output int   mismatch_count,
  output int   pending_count
);

  localparam int MAX_DIGITS  = 20;
  localparam int SHOWN_LIMIT = 10;

  typedef struct packed {
    brand_t                   brand;
    logic [DIGIT_TOTAL_W-1:0] digit_total;
    logic                     checksum_ok;
  } card_result_t;

  card_result_t expected_cards[$];
  int           mismatches = 0;
  int           pending_q  = 0;

  assign mismatch_count = mismatches;
  assign pending_count  = pending_q;

  function automatic card_result_t classify_card(input logic [INPUT_BITS-1:0] number);
    longint unsigned value;
    digit_t          dig[MAX_DIGITS];
    int              count;
    int              sum;
    int              d;
    int              i;
    card_result_t    res;
    value = 64'(number);
    count = 0;
    sum   = 0;
    while (value != 0 && count < MAX_DIGITS) begin
      dig[count] = digit_t'(value % 10);
      value      = value / 10;
      count++;
    end
    for (i = 0; i < count; i++) begin
      d = int'(dig[i]);
      // every second digit from the right is doubled, product digits summed
      if (i % 2 == 1) begin
        d = 2 * d;
        d = d % 10 + d / 10;
      end
      sum += d;
    end
    res.checksum_ok = (sum % 10 == 0);
    res.digit_total = DIGIT_TOTAL_W'(count);
    res.brand       = BRAND_NONE;
    if (res.checksum_ok && count >= 2) begin
      if ((count == LEN_SHORT || count == LEN_LONG) && dig[count-1] == DIG_FOUR) begin
        res.brand = BRAND_LEAD4;
      end else if (count == LEN_MID && dig[count-1] == DIG_THREE &&
                   (dig[count-2] == DIG_FOUR || dig[count-2] == DIG_SEVEN)) begin
        res.brand = BRAND_P34_37;
      end else if (count == LEN_LONG && dig[count-1] == DIG_FIVE &&
                   dig[count-2] >= DIG_ONE && dig[count-2] <= DIG_FIVE) begin
        res.brand = BRAND_P51_55;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    card_result_t want;
    card_result_t got;
    if (rst_n) begin
      // check the result side first so a new card never matches a stray result
      if (out_ch.valid && out_ch.ready) begin
        got.brand       = out_ch.brand;
        got.digit_total = out_ch.digit_total;
        got.checksum_ok = out_ch.checksum_ok;
        if (expected_cards.size() == 0) begin
          if (mismatches < SHOWN_LIMIT)
            $display("%0t: result with nothing expected: brand %0d digits %0d ok %0d",
                     $realtime, got.brand, got.digit_total, got.checksum_ok);
          mismatches++;
        end else begin
          want = expected_cards.pop_front();
          if (got != want) begin
            if (mismatches < SHOWN_LIMIT)
              $display("%0t: mismatch brand/digits/ok: expected %0d/%0d/%0d got %0d/%0d/%0d",
                       $realtime, want.brand, want.digit_total, want.checksum_ok,
                       got.brand, got.digit_total, got.checksum_ok);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_cards.push_back(classify_card(in_ch.card_number));
    end
    pending_q <= expected_cards.size();
  end

endmodule

// ===== bench/tb_luhn_card_number_classifier.sv =====
`timescale 1ns / 1ps

module tb_luhn_card_number_classifier;

  localparam int INPUT_BITS  = 63;
  localparam int RANDOM_CARDS = 450;
  localparam int QUIET_CARDS  = 60;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst_n;
  int   mismatches;
  int   pending;
  int   cycles = 0;
  bit   quiet = 1'b0;

  lcc_in_if #(.INPUT_BITS(INPUT_BITS)) in_if ();
  lcc_out_if out_if ();

  luhn_card_number_classifier #(.INPUT_BITS(INPUT_BITS)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  card_check_monitor #(.INPUT_BITS(INPUT_BITS)) u_monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_if),
    .out_ch         (out_if),
    .mismatch_count (mismatches),
    .pending_count  (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // builds a len-digit number with the given leading digits; next < 0 leaves it random
  function automatic logic [INPUT_BITS-1:0] make_card(input int len, input int lead,
                                                      input int next, input bit good);
    int              dig[19];
    int              sum;
    int              d;
    int              i;
    longint unsigned value;
    sum   = 0;
    value = 0;
    for (i = 0; i < len; i++) dig[i] = $urandom_range(0, 9);
    dig[len-1] = lead;
    if (next >= 0) dig[len-2] = next;
    for (i = 1; i < len; i++) begin
      d = dig[i];
      if (i % 2 == 1) begin
        d = 2 * d;
        d = d % 10 + d / 10;
      end
      sum += d;
    end
    dig[0] = (10 - sum % 10) % 10;
    if (!good) dig[0] = (dig[0] + $urandom_range(1, 9)) % 10;
    for (i = len - 1; i >= 0; i--) value = value * 10 + longint'(dig[i]);
    return value[INPUT_BITS-1:0];
  endfunction

  task automatic send_card(input logic [INPUT_BITS-1:0] number);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.card_number <= number;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // result side stalls in bursts
  initial begin : result_stall
    int stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 19) == 0) begin
        stall_left   = $urandom_range(1, 16) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [63:0]           raw;
    logic [INPUT_BITS-1:0] number;
    int                    n;
    int                    len;
    int                    lead;
    int                    pick;
    bit                    good;
    in_if.valid       = 1'b0;
    in_if.card_number = '0;
    rst_n             = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero, field extremes, short numbers, each brand and near misses
    send_card('0);
    send_card(INPUT_BITS'(1));
    send_card('1);
    send_card(INPUT_BITS'(1) << (INPUT_BITS - 1));
    send_card(INPUT_BITS'(9));
    send_card(INPUT_BITS'(18));
    send_card(INPUT_BITS'(59));
    send_card(make_card(13, 4, -1, 1'b1));
    send_card(make_card(16, 4, -1, 1'b1));
    send_card(make_card(13, 4, -1, 1'b0));
    send_card(make_card(15, 3, 4, 1'b1));
    send_card(make_card(15, 3, 7, 1'b1));
    send_card(make_card(15, 3, 7, 1'b0));
    send_card(make_card(15, 3, 5, 1'b1));
    send_card(make_card(16, 5, 1, 1'b1));
    send_card(make_card(16, 5, 5, 1'b1));
    send_card(make_card(16, 5, 3, 1'b0));
    send_card(make_card(16, 5, 0, 1'b1));
    send_card(make_card(16, 5, 6, 1'b1));
    send_card(make_card(15, 4, -1, 1'b1));
    send_card(make_card(14, 3, 7, 1'b1));
    send_card(make_card(16, 3, 4, 1'b1));
    send_card(make_card(19, 8, -1, 1'b1));
    send_card(make_card(12, 4, -1, 1'b1));

    for (n = 0; n < RANDOM_CARDS; n++) begin
      if (n == RANDOM_CARDS - QUIET_CARDS) quiet = 1'b1;
      good = ($urandom_range(0, 4) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        case ($urandom_range(0, 5))
          0: number = make_card($urandom_range(0, 1) ? 16 : 13, 4, -1, good);
          1: number = make_card(15, 3, $urandom_range(0, 1) ? 7 : 4, good);
          2: number = make_card(16, 5, $urandom_range(1, 5), good);
          3: begin
            len    = $urandom_range(11, 18);
            number = make_card(len, 4, -1, good);
          end
          4: begin
            if ($urandom_range(0, 1))
              number = make_card(15, 3, $urandom_range(0, 1) ? $urandom_range(5, 6)
                                                              : $urandom_range(8, 9), good);
            else
              number = make_card(16, 5, $urandom_range(0, 1) ? 0 : $urandom_range(6, 9),
                                 good);
          end
          default: begin
            len    = $urandom_range(12, 17);
            number = make_card(len, $urandom_range(3, 5), $urandom_range(0, 9), good);
          end
        endcase
      end else if (pick < 80) begin
        len    = $urandom_range(2, 19);
        lead   = (len == 19) ? $urandom_range(1, 8) : $urandom_range(1, 9);
        number = make_card(len, lead, -1, good);
      end else begin
        raw    = {$urandom, $urandom};
        number = raw[INPUT_BITS-1:0] >> $urandom_range(0, INPUT_BITS - 1);
      end
      send_card(number);
    end
    in_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
